[hdl/fre_pkg.sv]
// ----------------------------------------------------------------------------
// fre_pkg: shared types and constants for the frame remap engine
// Geometry and tone codes, register map and default frame size.
// ----------------------------------------------------------------------------
package fre_pkg;

   // default side length of the square frame, in pixels
   localparam int SIDE_DEFAULT = 256;

   // fixed field widths
   localparam int COORD_W = 8;
   localparam int PIXEL_W = 8;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int GEO_W      = 4;
   localparam int TONE_W     = 2;

   // register index, taken from the word address bit
   typedef enum logic {
      REG_GEOMETRY = 1'b0,
      REG_TONE     = 1'b1
   } csr_reg_type;

   // value read outside the scaled area of a downscaled frame
   localparam logic [PIXEL_W-1:0] SHRINK_FILL = 8'd255;
   // value returned for a coordinate beyond the frame
   localparam logic [PIXEL_W-1:0] OUTSIDE_FILL = 8'd0;
   // offset added by the lighten tone
   localparam logic [PIXEL_W-1:0] LIGHTEN_BIAS = 8'd127;

   typedef enum logic [GEO_W-1:0] {
      GEO_NONE       = 4'd0,
      GEO_FLIP_ROWS  = 4'd1,
      GEO_FLIP_COLS  = 4'd2,
      GEO_ROT_90     = 4'd3,
      GEO_ROT_180    = 4'd4,
      GEO_ROT_270    = 4'd5,
      GEO_MIRROR_L   = 4'd6,
      GEO_MIRROR_R   = 4'd7,
      GEO_MIRROR_U   = 4'd8,
      GEO_MIRROR_D   = 4'd9,
      GEO_SHRINK_2   = 4'd10,
      GEO_SHRINK_3   = 4'd11,
      GEO_SHRINK_4   = 4'd12
   } geo_mode_type;

   typedef enum logic [TONE_W-1:0] {
      TONE_NONE    = 2'd0,
      TONE_DARKEN  = 2'd1,
      TONE_LIGHTEN = 2'd2
   } tone_mode_type;

   // request kind carried in req_type
   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

endpackage

[hdl/fre_if.sv]
// ----------------------------------------------------------------------------
// fre_if: stream channels of the frame remap engine
// Request channel (load or read of a pixel) and response channel.
// ----------------------------------------------------------------------------
interface fre_req_if
   import fre_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [COORD_W-1:0] row;
   logic [COORD_W-1:0] col;
   logic [PIXEL_W-1:0] pixel_in;

   modport source (output valid, req_type, row, col, pixel_in, input ready);
   modport sink   (input valid, req_type, row, col, pixel_in, output ready);
endinterface

interface fre_rsp_if
   import fre_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_row;
   logic [COORD_W-1:0] out_col;
   logic [PIXEL_W-1:0] pixel_out;

   modport source (output valid, out_row, out_col, pixel_out, input ready);
   modport sink   (input valid, out_row, out_col, pixel_out, output ready);
endinterface

[hdl/frame_remap_engine.sv]
// ----------------------------------------------------------------------------
// frame_remap_engine: square grayscale frame store with remapped reads
// Loads write one pixel; reads return the pixel that the configured
// geometric transform places at (row, col), after a tone adjustment.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | beat contents
//  ---------+-----------+---------------------+-------------------------------
//  req_bus  | in        | valid/ready         | req_type, row, col, pixel_in
//  rsp_bus  | out       | valid/ready         | out_row, out_col, pixel_out
//  csr      | in        | APB, pready always 1| geometry_mode @0, tone_mode @4
//
//  One beat is accepted per cycle unless the pipeline stalls, loads and reads
//  mixed freely. A read's response goes through the store's registered read,
//  taken at the accepting edge, then through tone and the output register,
//  which loads once it is free.
//  Reset clears the mode registers and the pipeline valids; the store itself
//  is not cleared and needs no sweep.
//  A stalled response holds the pipeline; requests stop only once both
//  pipeline stages are full.
//
module frame_remap_engine
   import fre_pkg::*;
#(
   parameter int SIDE = SIDE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   fre_req_if.sink               req_bus,
   fre_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SW    = $clog2(SIDE);
   localparam int CW    = ((SW > COORD_W) ? SW : COORD_W) + 2;
   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [CW-1:0] SIDE_C = CW'(SIDE);
   localparam logic [CW-1:0] LAST_C = CW'(SIDE - 1);
   localparam logic [CW-1:0] HALF_C = CW'(SIDE / 2);
   localparam logic [AW-1:0] SIDE_A = AW'(SIDE);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [GEO_W-1:0]  geo_ff, geo_in;
   logic [TONE_W-1:0] tone_ff, tone_in;
   logic              csr_wr;
   csr_reg_type       csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_sel = csr_reg_type'(paddr[2]);

   // decode register writes
   always_comb begin
      geo_in  = geo_ff;
      tone_in = tone_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            REG_GEOMETRY: geo_in  = pwdata[GEO_W-1:0];
            REG_TONE:     tone_in = pwdata[TONE_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff  <= GEO_NONE;
         tone_ff <= TONE_NONE;
      end else begin
         geo_ff  <= geo_in;
         tone_ff <= tone_in;
      end
   end

   // register readback
   always_comb begin
      prdata = '0;
      unique case (csr_sel)
         REG_GEOMETRY: prdata = CSR_DATA_W'(geo_ff);
         REG_TONE:     prdata = CSR_DATA_W'(tone_ff);
         default:      ;
      endcase
   end

   // ------------------------------------------------------------------
   // pipeline control
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, s1_adv, req_acc, rd_acc, ld_acc;

   assign out_free        = !out_valid_ff || rsp_bus.ready;
   assign s1_adv          = s1_valid_ff && out_free;
   assign req_bus.ready   = !s1_valid_ff || s1_adv;
   assign req_acc         = req_bus.valid && req_bus.ready;
   assign rd_acc          = req_acc && (req_bus.req_type == REQ_READ);
   assign ld_acc          = req_acc && (req_bus.req_type == REQ_LOAD);

   // ------------------------------------------------------------------
   // stage 0: source coordinate computation
   // ------------------------------------------------------------------
   logic [CW-1:0] r_w, c_w, sr, sc, kk, rk, ck, rk_end, ck_end;
   logic          in_frame, shrink_mode, shrink_out;
   logic [AW-1:0] rd_addr, wr_addr;

   assign r_w      = CW'(req_bus.row);
   assign c_w      = CW'(req_bus.col);
   assign in_frame = (r_w < SIDE_C) && (c_w < SIDE_C);

   // scale factor for the downscale modes
   always_comb begin
      kk          = CW'(2);
      shrink_mode = 1'b0;
      unique case (geo_mode_type'(geo_ff))
         GEO_SHRINK_2: begin kk = CW'(2); shrink_mode = 1'b1; end
         GEO_SHRINK_3: begin kk = CW'(3); shrink_mode = 1'b1; end
         GEO_SHRINK_4: begin kk = CW'(4); shrink_mode = 1'b1; end
         default:      ;
      endcase
   end

   assign rk         = CW'(r_w * kk);
   assign ck         = CW'(c_w * kk);
   assign rk_end     = rk + kk - CW'(1);
   assign ck_end     = ck + kk - CW'(1);
   assign shrink_out = shrink_mode && ((rk > LAST_C) || (ck > LAST_C));

   // map output position to source position
   always_comb begin
      sr = r_w;
      sc = c_w;
      unique case (geo_mode_type'(geo_ff)) inside
         GEO_FLIP_ROWS: sr = LAST_C - r_w;
         GEO_FLIP_COLS: sc = LAST_C - c_w;
         GEO_ROT_90: begin
            sr = LAST_C - c_w;
            sc = r_w;
         end
         GEO_ROT_180: begin
            sr = LAST_C - r_w;
            sc = LAST_C - c_w;
         end
         GEO_ROT_270: begin
            sr = c_w;
            sc = LAST_C - r_w;
         end
         GEO_MIRROR_L: if ((LAST_C - c_w) < HALF_C) sc = LAST_C - c_w;
         GEO_MIRROR_R: if (c_w < HALF_C) sc = LAST_C - c_w;
         GEO_MIRROR_U: if ((LAST_C - r_w) < HALF_C) sr = LAST_C - r_w;
         GEO_MIRROR_D: if (r_w < HALF_C) sr = LAST_C - r_w;
         GEO_SHRINK_2, GEO_SHRINK_3, GEO_SHRINK_4: begin
            sr = (rk_end > LAST_C) ? LAST_C : rk_end;
            sc = (ck_end > LAST_C) ? LAST_C : ck_end;
         end
         default: ;
      endcase
   end

   assign rd_addr = AW'(AW'(sr) * SIDE_A) + AW'(sc);
   assign wr_addr = AW'(AW'(r_w) * SIDE_A) + AW'(c_w);

   // ------------------------------------------------------------------
   // frame store
   // ------------------------------------------------------------------
   logic [PIXEL_W-1:0] ram_q;

   fre_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ld_acc && in_frame),
      .wr_addr (wr_addr),
      .wr_data (req_bus.pixel_in),
      .rd_en   (rd_acc),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // ------------------------------------------------------------------
   // stage 1: pixel select and tone
   // ------------------------------------------------------------------
   logic [COORD_W-1:0] s1_row_ff, s1_col_ff;
   logic               s1_use_ram_ff, s1_tone_en_ff;
   logic [PIXEL_W-1:0] s1_fill_ff;
   logic [PIXEL_W-1:0] s1_pix, s1_toned;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rd_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // capture read beat side info
   always_ff @(posedge clock) begin
      if (rd_acc) begin
         s1_row_ff     <= req_bus.row;
         s1_col_ff     <= req_bus.col;
         s1_use_ram_ff <= in_frame && !shrink_out;
         s1_tone_en_ff <= in_frame;
         s1_fill_ff    <= in_frame ? SHRINK_FILL : OUTSIDE_FILL;
      end
   end

   assign s1_pix = s1_use_ram_ff ? ram_q : s1_fill_ff;

   // apply tone adjustment
   always_comb begin
      s1_toned = s1_pix;
      if (s1_tone_en_ff) begin
         case (tone_ff)
            TONE_DARKEN:  s1_toned = s1_pix - (s1_pix >> 1);
            TONE_LIGHTEN: s1_toned = (s1_pix >> 1) + LIGHTEN_BIAS;
            default:      s1_toned = s1_pix;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   logic [COORD_W-1:0] out_row_ff, out_col_ff;
   logic [PIXEL_W-1:0] out_pix_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_row_ff <= s1_row_ff;
         out_col_ff <= s1_col_ff;
         out_pix_ff <= s1_toned;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.out_row   = out_row_ff;
   assign rsp_bus.out_col   = out_col_ff;
   assign rsp_bus.pixel_out = out_pix_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   // a full, stalled pipeline must refuse new beats
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request accepted while pipeline full and stalled");

   // every accepted read occupies stage 1 next cycle
   a_read_enters: assert property (@(posedge clock) disable iff (reset)
      rd_acc |=> s1_valid_ff)
      else $error("accepted read lost before stage 1");

   // a load into an empty pipeline leaves it empty
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (ld_acc && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("load produced a pipeline entry");

endmodule

[hdl/fre_ram.sv]
// ----------------------------------------------------------------------------
// fre_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, hold data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the frame remap engine
// Drives load and read beats with random gaps on both channels, keeps its own
// copy of the frame and the mode registers, predicts every read response, and
// checks responses in order. Modes are changed over APB between phases.
// ----------------------------------------------------------------------------
module tb;
   import fre_pkg::*;

   localparam int FRAME_SIDE  = SIDE_DEFAULT;
   localparam int FRAME_PIXELS = FRAME_SIDE * FRAME_SIDE;
   localparam int PIPE_DRAIN  = 8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_BEATS = 50;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      req_kind_type       kind;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIXEL_W-1:0] pixel;
   } pixel_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIXEL_W-1:0] pixel;
   } pixel_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fre_req_if req_bus ();
   fre_rsp_if rsp_bus ();

   frame_remap_engine dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // frame image as the block should hold it, updated on accepted loads
   logic [PIXEL_W-1:0] frame_img [0:FRAME_PIXELS-1];
   // pixels that some queued load will have written, used while generating
   bit                 gen_written [0:FRAME_PIXELS-1];
   int                 written_idx [$];

   logic [GEO_W-1:0]   cur_geometry;
   logic [TONE_W-1:0]  cur_tone;

   pixel_req_type      pending_reqs [$];
   pixel_rsp_type      expected_pixels [$];

   logic               req_taken;
   int                 req_gap;
   int                 rsp_gap;
   bit                 calm_phase;
   int                 mismatch_count;

   // source pixel of output (r, c); returns 0 where no fetch happens
   function automatic bit remap_source(input logic [GEO_W-1:0] geo, input int r,
                                       input int c, output int sr, output int sc);
      int last;
      int half;
      int k;
      last = FRAME_SIDE - 1;
      half = FRAME_SIDE / 2;
      k    = 0;
      sr   = r;
      sc   = c;
      case (geo)
         GEO_FLIP_ROWS: sr = last - r;
         GEO_FLIP_COLS: sc = last - c;
         GEO_ROT_90: begin
            sr = last - c;
            sc = r;
         end
         GEO_ROT_180: begin
            sr = last - r;
            sc = last - c;
         end
         GEO_ROT_270: begin
            sr = c;
            sc = last - r;
         end
         GEO_MIRROR_L: if (last - c < half) sc = last - c;
         GEO_MIRROR_R: if (c < half) sc = last - c;
         GEO_MIRROR_U: if (last - r < half) sr = last - r;
         GEO_MIRROR_D: if (r < half) sr = last - r;
         GEO_SHRINK_2: k = 2;
         GEO_SHRINK_3: k = 3;
         GEO_SHRINK_4: k = 4;
         default: ;
      endcase
      if (k != 0) begin
         // outside the scaled area nothing is fetched
         if (r * k > last || c * k > last) return 1'b0;
         sr = (r * k + k - 1 > last) ? last : r * k + k - 1;
         sc = (c * k + k - 1 > last) ? last : c * k + k - 1;
      end
      return 1'b1;
   endfunction

   function automatic logic [PIXEL_W-1:0] tone_adjust(input logic [TONE_W-1:0] tone,
                                                      input logic [PIXEL_W-1:0] p);
      case (tone)
         TONE_DARKEN:  return p - (p >> 1);
         TONE_LIGHTEN: return (p >> 1) + LIGHTEN_BIAS;
         default:      return p;
      endcase
   endfunction

   function automatic pixel_rsp_type remap_pixel(input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c);
      pixel_rsp_type rsp;
      int sr;
      int sc;
      logic [PIXEL_W-1:0] raw;
      if (remap_source(cur_geometry, int'(r), int'(c), sr, sc))
         raw = frame_img[sr * FRAME_SIDE + sc];
      else raw = SHRINK_FILL;
      rsp.row   = r;
      rsp.col   = c;
      rsp.pixel = tone_adjust(cur_tone, raw);
      return rsp;
   endfunction

   // mostly no gap, some short ones, a few long stalls
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_phase || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_coord();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return FRAME_SIDE - 1;
         2:       return $urandom_range(FRAME_SIDE / 2 - 2, FRAME_SIDE / 2 + 1);
         default: return $urandom_range(0, FRAME_SIDE - 1);
      endcase
   endfunction

   function automatic void push_load(input int r, input int c, input int p);
      pixel_req_type beat;
      int idx;
      beat.kind  = REQ_LOAD;
      beat.row   = COORD_W'(r);
      beat.col   = COORD_W'(c);
      beat.pixel = PIXEL_W'(p);
      pending_reqs.push_back(beat);
      idx = r * FRAME_SIDE + c;
      if (!gen_written[idx]) begin
         gen_written[idx] = 1'b1;
         written_idx.push_back(idx);
      end
   endfunction

   // never read a pixel that was not loaded: load the source first if needed
   function automatic void push_read(input int r, input int c);
      pixel_req_type beat;
      int sr;
      int sc;
      if (remap_source(cur_geometry, r, c, sr, sc) && !gen_written[sr * FRAME_SIDE + sc])
         push_load(sr, sc, $urandom_range(0, 255));
      beat.kind  = REQ_READ;
      beat.row   = COORD_W'(r);
      beat.col   = COORD_W'(c);
      beat.pixel = PIXEL_W'($urandom_range(0, 255));
      pending_reqs.push_back(beat);
   endfunction

   task automatic note_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("mismatch: %s", text);
   endtask

   // one APB transfer, setup then access
   task automatic csr_cycle(input logic wr, input csr_reg_type which,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = CSR_ADDR_W'({which, 2'b00});
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // write both modes, read them back, then open the next phase
   task automatic set_modes(input logic [GEO_W-1:0] geo, input logic [TONE_W-1:0] tone);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] rdata;
      // upper bits are junk half the time and must be dropped
      wdata = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
      wdata[GEO_W-1:0] = geo;
      csr_cycle(1'b1, REG_GEOMETRY, wdata, rdata);
      cur_geometry = geo;
      wdata = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
      wdata[TONE_W-1:0] = tone;
      csr_cycle(1'b1, REG_TONE, wdata, rdata);
      cur_tone = tone;
      csr_cycle(1'b0, REG_GEOMETRY, '0, rdata);
      if (rdata !== CSR_DATA_W'(geo))
         note_mismatch($sformatf("geometry_mode read expected %0h got %0h", geo, rdata));
      csr_cycle(1'b0, REG_TONE, '0, rdata);
      if (rdata !== CSR_DATA_W'(tone))
         note_mismatch($sformatf("tone_mode read expected %0h got %0h", tone, rdata));
      @(posedge clock);
      calm_phase = ($urandom_range(0, 3) == 0);
   endtask

   // wait for every beat to go out and every response to come back
   task automatic wait_idle();
      do @(negedge clock); while (pending_reqs.size() != 0 || expected_pixels.size() != 0);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic run_phase(input logic [GEO_W-1:0] geo, input logic [TONE_W-1:0] tone,
                            input int beats);
      int roll;
      int idx;
      set_modes(geo, tone);
      while (pending_reqs.size() < beats) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            push_load(pick_coord(), pick_coord(), $urandom_range(0, 255));
         end else if (roll < 35 && written_idx.size() != 0) begin
            // overwrite a pixel already in the frame
            idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
            push_load(idx / FRAME_SIDE, idx % FRAME_SIDE, $urandom_range(0, 255));
         end else if (roll < 50 && written_idx.size() != 0) begin
            idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
            push_read(idx / FRAME_SIDE, idx % FRAME_SIDE);
         end else begin
            push_read(pick_coord(), pick_coord());
         end
      end
      wait_idle();
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // abort a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   // request driver: advance to the next beat once the current one is taken
   always @(negedge clock) begin
      pixel_req_type head;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            head = pending_reqs[0];
            req_bus.valid    <= 1'b1;
            req_bus.req_type <= head.kind;
            req_bus.row      <= head.row;
            req_bus.col      <= head.col;
            req_bus.pixel_in <= head.pixel;
            req_gap = pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response side: stall at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      pixel_rsp_type want;
      pixel_rsp_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.row   = rsp_bus.out_row;
            got.col   = rsp_bus.out_col;
            got.pixel = rsp_bus.pixel_out;
            if (expected_pixels.size() == 0) begin
               note_mismatch($sformatf("unexpected beat row %0d col %0d pixel %0d",
                                       got.row, got.col, got.pixel));
            end else begin
               want = expected_pixels.pop_front();
               if (got.row !== want.row || got.col !== want.col || got.pixel !== want.pixel)
                  note_mismatch($sformatf(
                     "expected row %0d col %0d pixel %0d, got row %0d col %0d pixel %0d",
                     want.row, want.col, want.pixel, got.row, got.col, got.pixel));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            void'(pending_reqs.pop_front());
            if (req_bus.req_type == REQ_LOAD)
               frame_img[req_bus.row * FRAME_SIDE + req_bus.col] = req_bus.pixel_in;
            else
               expected_pixels.push_back(remap_pixel(req_bus.row, req_bus.col));
         end
      end
      req_taken <= req_bus.valid && req_bus.ready;
   end

   initial begin
      // hold every input at a known value through reset
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_LOAD;
      req_bus.row      = '0;
      req_bus.col      = '0;
      req_bus.pixel_in = '0;
      rsp_bus.ready    = 1'b0;
      req_taken        = 1'b0;
      req_gap          = 0;
      rsp_gap          = 0;
      calm_phase       = 1'b0;
      mismatch_count   = 0;
      cur_geometry     = GEO_NONE;
      cur_tone         = TONE_NONE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners and center pixels at distinct values, read back plainly
      set_modes(GEO_NONE, TONE_NONE);
      push_load(0, 0, 8'h00);
      push_load(0, FRAME_SIDE - 1, 8'hFF);
      push_load(FRAME_SIDE - 1, 0, 8'h55);
      push_load(FRAME_SIDE - 1, FRAME_SIDE - 1, 8'hAA);
      push_load(FRAME_SIDE / 2 - 1, FRAME_SIDE / 2, 8'h80);
      push_load(FRAME_SIDE / 2, FRAME_SIDE / 2 - 1, 8'h7F);
      push_read(0, 0);
      push_read(0, FRAME_SIDE - 1);
      push_read(FRAME_SIDE - 1, 0);
      push_read(FRAME_SIDE - 1, FRAME_SIDE - 1);
      push_read(FRAME_SIDE / 2 - 1, FRAME_SIDE / 2);
      push_read(FRAME_SIDE / 2, FRAME_SIDE / 2 - 1);
      // read right behind a load of the same pixel
      push_load(0, 0, 8'hFF);
      push_read(0, 0);
      wait_idle();

      // downscale edges: last block, first block, fill outside the scaled area
      set_modes(GEO_SHRINK_4, TONE_LIGHTEN);
      push_read(FRAME_SIDE / 4 - 1, FRAME_SIDE / 4 - 1);
      push_read(0, 0);
      push_read(FRAME_SIDE / 4, 10);
      push_read(FRAME_SIDE - 1, FRAME_SIDE - 1);
      wait_idle();

      set_modes(GEO_ROT_90, TONE_DARKEN);
      push_read(0, 0);
      push_read(FRAME_SIDE - 1, FRAME_SIDE - 1);
      wait_idle();

      // every geometry code, including the unused ones, and every tone code
      for (int g = 0; g < 16; g++) run_phase(GEO_W'(g), TONE_W'(g % 4), PHASE_BEATS);
      run_phase(GEO_SHRINK_2, TONE_LIGHTEN, PHASE_BEATS);
      run_phase(GEO_ROT_270, 2'd3, PHASE_BEATS);
      run_phase(GEO_NONE, TONE_NONE, PHASE_BEATS);

      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/fre_pkg.sv
hdl/fre_if.sv
hdl/fre_ram.sv
hdl/frame_remap_engine.sv
sim/tb.sv
